// ===== rtl/obstacle_cell_height_gate_assert.svh =====
// assertion macros for the height gate checker
`ifndef OBSTACLE_CELL_HEIGHT_GATE_ASSERT_SVH
`define OBSTACLE_CELL_HEIGHT_GATE_ASSERT_SVH

// implication in the same cycle, skipped while in reset
`define OCHG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ochg check failed");

// implication in the next cycle, skipped while in reset
`define OCHG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ochg check failed");

// implication in the next cycle, also checked while in reset
`define OCHG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ochg check failed");

`endif

// ===== rtl/ochg_pkg.sv =====
// types, constants and field layout for the obstacle cell height gate
package ochg_pkg;

  localparam int COUNT_MAX = 1023;
  localparam int CNT_W     = 10;
  localparam int H_W       = 16;
  localparam int MIN_W     = 15;
  localparam int IDX_W     = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  // counts saturate at COUNT_MAX, clipped to what the field can hold
  localparam logic [CNT_W-1:0] CNT_LIMIT =
    CNT_W'((COUNT_MAX > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : COUNT_MAX);

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_PROTRUSION = 3'd1,
    ST_DENSE      = 3'd2,
    ST_GEOMFAIL   = 3'd3,
    ST_OVERHEAD   = 3'd4,
    ST_EVIDENCE   = 3'd5,
    ST_HEIGHT     = 3'd6,
    ST_NOSAMPLES  = 3'd7
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_HEIGHT  = 2'd0,
    REG_STEP_UP     = 2'd1,
    REG_BODY_CEIL   = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MIN_W-1:0]  min_height;
    logic [MIN_W-1:0]  step_up;
    logic signed [H_W-1:0] body_ceiling;
  } cfg_t;

  typedef struct packed {
    status_t               status;
    logic signed [H_W-1:0] support;
    logic                  support_valid;
    logic signed [H_W-1:0] map_h;
    logic signed [H_W-1:0] body_h;
    logic signed [H_W-1:0] grav_h;
  } item_t;

  typedef struct packed {
    logic                  seen;
    logic [CNT_W-1:0]      sample_tally;
    logic [CNT_W-1:0]      pass_tally;
    logic signed [H_W-1:0] peak_map;
    logic signed [H_W-1:0] low_body;
    logic signed [H_W-1:0] low_grav;
    logic                  f_min;
    logic                  f_step;
    logic                  f_ceil;
    logic                  f_floor;
  } stats_t;

  typedef struct packed {
    status_t               final_code;
    logic                  wants_publish;
    logic                  had_samples;
    logic                  any_above_min;
    logic                  any_above_step;
    logic                  any_below_ceiling;
    logic                  any_above_floor;
    logic [CNT_W-1:0]      total_samples;
    logic [CNT_W-1:0]      passing_samples;
    logic signed [H_W-1:0] peak_map_height;
    logic signed [H_W-1:0] lowest_body_height;
    logic signed [H_W-1:0] lowest_gravity_height;
  } result_t;

endpackage

// ===== rtl/ochg_stats.sv =====
// per-item gate logic: next cell statistics and the finish decision
module ochg_stats (
  input  ochg_pkg::cfg_t   cfg,
  input  ochg_pkg::kind_t  kind,
  input  ochg_pkg::item_t  item,
  input  ochg_pkg::stats_t stats,
  output ochg_pkg::stats_t stats_next,
  output ochg_pkg::result_t res
);
  import ochg_pkg::*;

  logic signed [H_W+1:0] map_x;
  logic signed [H_W+1:0] min_lim;
  logic signed [H_W+1:0] step_lim;
  logic signed [H_W:0]   grav_x;
  logic signed [H_W:0]   floor_x;
  logic a_min;
  logic a_step;
  logic b_ceil;
  logic a_floor;
  logic published;

  // exact sums in 18 bits, no wrap possible
  assign map_x    = {{2{item.map_h[H_W-1]}}, item.map_h};
  assign min_lim  = {{2{item.support[H_W-1]}}, item.support} + {3'b000, cfg.min_height};
  assign step_lim = {{2{item.support[H_W-1]}}, item.support} + {3'b000, cfg.step_up};
  assign grav_x   = {item.grav_h[H_W-1], item.grav_h};
  assign floor_x  = {2'b00, cfg.min_height};

  assign a_min   = item.support_valid && (map_x >= min_lim);
  assign a_step  = item.support_valid && (map_x > step_lim);
  assign b_ceil  = item.body_h <= cfg.body_ceiling;
  assign a_floor = (item.status != ST_GEOMFAIL) || (grav_x >= floor_x);

  assign published = (item.status == ST_PROTRUSION) || (item.status == ST_DENSE) ||
                     (item.status == ST_GEOMFAIL) || (item.status == ST_OVERHEAD);

  always_comb begin
    stats_next = stats;
    unique case (kind)
      KIND_SAMPLE: begin
        stats_next.seen = 1'b1;
        if (!stats.seen) begin
          stats_next.peak_map = item.map_h;
          stats_next.low_body = item.body_h;
          stats_next.low_grav = item.grav_h;
        end else begin
          if (item.map_h > stats.peak_map) stats_next.peak_map = item.map_h;
          if (item.body_h < stats.low_body) stats_next.low_body = item.body_h;
          if (item.grav_h < stats.low_grav) stats_next.low_grav = item.grav_h;
        end
        if (stats.sample_tally < CNT_LIMIT) stats_next.sample_tally = stats.sample_tally + 1'b1;
        if (a_min && b_ceil && a_floor && (stats.pass_tally < CNT_LIMIT)) begin
          stats_next.pass_tally = stats.pass_tally + 1'b1;
        end
        stats_next.f_min   = stats.f_min | a_min;
        stats_next.f_step  = stats.f_step | a_step;
        stats_next.f_ceil  = stats.f_ceil | b_ceil;
        stats_next.f_floor = stats.f_floor | a_floor;
      end
      KIND_FINISH: stats_next = '0;
      default: stats_next = stats;
    endcase
  end

  always_comb begin
    priority if (!published)           res.final_code = item.status;
    else if (!stats.seen)              res.final_code = ST_NOSAMPLES;
    else if (stats.pass_tally == '0)   res.final_code = ST_HEIGHT;
    else                               res.final_code = item.status;
    res.wants_publish         = published || (item.status == ST_HEIGHT) ||
                                (item.status == ST_NOSAMPLES);
    res.had_samples           = stats.seen;
    res.any_above_min         = stats.f_min;
    res.any_above_step        = stats.f_step;
    res.any_below_ceiling     = stats.f_ceil;
    res.any_above_floor       = stats.f_floor;
    res.total_samples         = stats.sample_tally;
    res.passing_samples       = stats.pass_tally;
    res.peak_map_height       = stats.peak_map;
    res.lowest_body_height    = stats.low_body;
    res.lowest_gravity_height = stats.low_grav;
  end

endmodule

// ===== rtl/obstacle_cell_height_gate.sv =====
// obstacle cell height gate: an item enters the input register, then a finish loads its
// decision into the result register; throughput one item per cycle; a sample never stalls,
// a finish waits only while the result register is still held by the downstream side
// result register frees the input side: new items enter while a result waits
// synchronous active-high reset clears valids and cell statistics and loads
// register defaults min 100, step 150, ceiling 2000
module obstacle_cell_height_gate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // status_code[2:0] support_height[18:3] support_valid[19] map_height[35:20]
  // body_height[51:36] gravity_height[67:52] zero[71:68]
  input  logic [ochg_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // final_code[2:0] wants_publish[3] had_samples[4] any_above_min[5]
  // any_above_step[6] any_below_ceiling[7] any_above_floor[8]
  // total_samples[18:9] passing_samples[28:19] peak_map_height[44:29]
  // lowest_body_height[60:45] lowest_gravity_height[76:61] zero[79:77]
  output logic [ochg_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ochg_pkg::IDX_W-1:0]      cfg_index,
  input  logic [ochg_pkg::H_W-1:0]        cfg_data
);
  import ochg_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  kind_t   in_kind;
  item_t   in_item;
  stats_t  stats;
  stats_t  stats_next;
  result_t res;
  logic    out_valid;
  result_t out_res;
  logic    in_advance;
  item_t   s_item;

  assign s_item.status        = status_t'(s_axis_tdata[2:0]);
  assign s_item.support       = s_axis_tdata[18:3];
  assign s_item.support_valid = s_axis_tdata[19];
  assign s_item.map_h         = s_axis_tdata[35:20];
  assign s_item.body_h        = s_axis_tdata[51:36];
  assign s_item.grav_h        = s_axis_tdata[67:52];

  // a sample always retires; a finish needs the result register free
  assign in_advance = in_valid &&
                      ((in_kind == KIND_SAMPLE) || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || in_advance;
  assign cfg_ready     = 1'b1;

  ochg_stats u_stats (
    .cfg        (cfg),
    .kind       (in_kind),
    .item       (in_item),
    .stats      (stats),
    .stats_next (stats_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_height   <= MIN_W'(100);
      cfg.step_up      <= MIN_W'(150);
      cfg.body_ceiling <= H_W'(2000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MIN_HEIGHT: cfg.min_height   <= cfg_data[MIN_W-1:0];
        REG_STEP_UP:    cfg.step_up      <= cfg_data[MIN_W-1:0];
        REG_BODY_CEIL:  cfg.body_ceiling <= cfg_data;
        REG_UNUSED:     cfg              <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_kind  <= KIND_SAMPLE;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
      in_kind  <= kind_t'(s_axis_tuser);
    end else if (in_advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_item <= s_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (in_advance) begin
      stats <= stats_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && (in_kind == KIND_FINISH)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && (in_kind == KIND_FINISH)) out_res <= res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000,
                          out_res.lowest_gravity_height,
                          out_res.lowest_body_height,
                          out_res.peak_map_height,
                          out_res.passing_samples,
                          out_res.total_samples,
                          out_res.any_above_floor,
                          out_res.any_below_ceiling,
                          out_res.any_above_step,
                          out_res.any_above_min,
                          out_res.had_samples,
                          out_res.wants_publish,
                          out_res.final_code};

endmodule

// ===== rtl/ochg_checker.sv =====
// port-level checks for the obstacle cell height gate, bound to the top level
`include "obstacle_cell_height_gate_assert.svh"

module ochg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ochg_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ochg_pkg::*;

  // result held while the downstream side stalls
  `OCHG_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // nothing shows right after reset
  `OCHG_ASSERT_NEXT_ALWAYS(a_out_idle_after_rst, clk, rst, !m_axis_tvalid)
  // passing count never exceeds the sample count
  `OCHG_ASSERT_NOW(a_pass_le_total, clk, rst, m_axis_tvalid, m_axis_tdata[28:19] <= m_axis_tdata[18:9])
  // sample flag agrees with the sample count
  `OCHG_ASSERT_NOW(a_seen_count, clk, rst, m_axis_tvalid, m_axis_tdata[4] == (m_axis_tdata[18:9] != '0))
  // a height or no-samples verdict is always published
  `OCHG_ASSERT_NOW(a_gate_publish, clk, rst, m_axis_tvalid && ((m_axis_tdata[2:0] == ST_HEIGHT) || (m_axis_tdata[2:0] == ST_NOSAMPLES)), m_axis_tdata[3])

endmodule

bind obstacle_cell_height_gate ochg_checker u_ochg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/obstacle_cell_height_gate_test.sv =====
// self-checking testbench for the obstacle cell height gate
module obstacle_cell_height_gate_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ochg_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 78;
  localparam int SAT_SAMPLES   = 1030;

  typedef struct packed {
    kind_t   kind;
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [H_W-1:0]        cfg_data = '0;

  // local copy of the registers and of the cell statistics
  logic [MIN_W-1:0]      cfg_min  = 15'd100;
  logic [MIN_W-1:0]      cfg_step = 15'd150;
  logic signed [H_W-1:0] cfg_ceil = 16'sd2000;
  logic                  cell_seen;
  int                    cell_samples;
  int                    cell_passes;
  int                    cell_peak_map;
  int                    cell_low_body;
  int                    cell_low_grav;
  logic                  hit_min, hit_step, hit_ceil, hit_floor;

  result_t   expected_decisions[$];
  stim_row_t directed_rows[$];
  int        fault_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  obstacle_cell_height_gate dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void clear_cell();
    cell_seen     = 1'b0;
    cell_samples  = 0;
    cell_passes   = 0;
    cell_peak_map = 0;
    cell_low_body = 0;
    cell_low_grav = 0;
    hit_min       = 1'b0;
    hit_step      = 1'b0;
    hit_ceil      = 1'b0;
    hit_floor     = 1'b0;
  endfunction

  // advance the cell statistics by one item; returns 1 when a decision comes out
  function automatic logic gate_cell_item(input kind_t k, input item_t it,
                                          output result_t res);
    int   sup, zm, zb, zg;
    logic a_min, a_step, b_ceil, a_floor, published;
    res = '0;
    if (k == KIND_SAMPLE) begin
      sup = int'($signed(it.support));
      zm  = int'($signed(it.map_h));
      zb  = int'($signed(it.body_h));
      zg  = int'($signed(it.grav_h));
      if (!cell_seen) begin
        cell_peak_map = zm;
        cell_low_body = zb;
        cell_low_grav = zg;
      end else begin
        if (zm > cell_peak_map) cell_peak_map = zm;
        if (zb < cell_low_body) cell_low_body = zb;
        if (zg < cell_low_grav) cell_low_grav = zg;
      end
      cell_seen = 1'b1;
      if (cell_samples < int'(CNT_LIMIT)) cell_samples++;
      a_min   = it.support_valid && (zm >= sup + int'(cfg_min));
      a_step  = it.support_valid && (zm > sup + int'(cfg_step));
      b_ceil  = zb <= int'(cfg_ceil);
      a_floor = (it.status != ST_GEOMFAIL) || (zg >= int'(cfg_min));
      hit_min   |= a_min;
      hit_step  |= a_step;
      hit_ceil  |= b_ceil;
      hit_floor |= a_floor;
      if (a_min && b_ceil && a_floor && cell_passes < int'(CNT_LIMIT)) cell_passes++;
      return 1'b0;
    end
    published = (it.status >= ST_PROTRUSION) && (it.status <= ST_OVERHEAD);
    if (!published) res.final_code = it.status;
    else if (!cell_seen) res.final_code = ST_NOSAMPLES;
    else if (cell_passes == 0) res.final_code = ST_HEIGHT;
    else res.final_code = it.status;
    res.wants_publish         = published || it.status == ST_HEIGHT ||
                                it.status == ST_NOSAMPLES;
    res.had_samples           = cell_seen;
    res.any_above_min         = hit_min;
    res.any_above_step        = hit_step;
    res.any_below_ceiling     = hit_ceil;
    res.any_above_floor       = hit_floor;
    res.total_samples         = CNT_W'(cell_samples);
    res.passing_samples       = CNT_W'(cell_passes);
    res.peak_map_height       = H_W'(cell_peak_map);
    res.lowest_body_height    = H_W'(cell_low_body);
    res.lowest_gravity_height = H_W'(cell_low_grav);
    clear_cell();
    return 1'b1;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(input item_t it);
    return {4'b0, it.grav_h, it.body_h, it.map_h, it.support_valid, it.support, it.status};
  endfunction

  function automatic result_t unpack_decision(input logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.final_code            = status_t'(d[2:0]);
    r.wants_publish         = d[3];
    r.had_samples           = d[4];
    r.any_above_min         = d[5];
    r.any_above_step        = d[6];
    r.any_below_ceiling     = d[7];
    r.any_above_floor       = d[8];
    r.total_samples         = d[18:9];
    r.passing_samples       = d[28:19];
    r.peak_map_height       = d[44:29];
    r.lowest_body_height    = d[60:45];
    r.lowest_gravity_height = d[76:61];
    return r;
  endfunction

  function automatic void show_decision(input string tag, input result_t r);
    $display("  %s code=%0d pub=%0b had=%0b min/step/ceil/floor=%b%b%b%b total=%0d pass=%0d",
             tag, r.final_code, r.wants_publish, r.had_samples, r.any_above_min,
             r.any_above_step, r.any_below_ceiling, r.any_above_floor,
             r.total_samples, r.passing_samples);
    $display("  %s peak_map=%0d low_body=%0d low_grav=%0d", tag,
             $signed(r.peak_map_height), $signed(r.lowest_body_height),
             $signed(r.lowest_gravity_height));
  endfunction

  // decision transfers checked against the oldest expectation
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = unpack_decision(m_axis_tdata);
      if (expected_decisions.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected decision at cycle %0d", cycle_count);
          show_decision("actual  ", got);
        end
      end else begin
        want = expected_decisions.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("decision mismatch at cycle %0d", cycle_count);
            show_decision("expected", want);
            show_decision("actual  ", got);
          end
        end
      end
    end
  end

  function automatic result_t empty_decision(input status_t code, input logic publish);
    result_t r;
    r = '0;
    r.final_code    = code;
    r.wants_publish = publish;
    return r;
  endfunction

  function automatic void add_row(input kind_t k, input status_t st, input int sup,
                                  input logic v, input int zm, input int zb, input int zg,
                                  input logic typed, input result_t want);
    stim_row_t row;
    row.kind             = k;
    row.it.status        = st;
    row.it.support       = H_W'(sup);
    row.it.support_valid = v;
    row.it.map_h         = H_W'(zm);
    row.it.body_h        = H_W'(zb);
    row.it.grav_h        = H_W'(zg);
    row.typed            = typed;
    row.want             = want;
    directed_rows.push_back(row);
  endfunction

  function automatic int any_height();
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int near_height(input int center, input int spread);
    int off;
    off = $urandom_range(2 * spread);
    return center + off - spread;
  endfunction

  // heights cluster around the current thresholds so that every gate flips
  function automatic item_t random_sample();
    item_t s;
    int    sup, thr, zm, zb, zg;
    s.status = ($urandom_range(3) == 0) ? ST_GEOMFAIL : status_t'($urandom_range(7));
    sup = ($urandom_range(4) == 0) ? any_height() : near_height(0, 1000);
    thr = $urandom_range(1) ? int'(cfg_min) : int'(cfg_step);
    case ($urandom_range(3))
      0:       zm = any_height();
      1:       zm = near_height(sup + thr, 200);
      default: zm = near_height(sup + thr, 2);
    endcase
    case ($urandom_range(3))
      0:       zb = any_height();
      1:       zb = near_height(int'(cfg_ceil), 300);
      default: zb = near_height(int'(cfg_ceil), 2);
    endcase
    case ($urandom_range(3))
      0:       zg = any_height();
      1:       zg = near_height(int'(cfg_min), 200);
      default: zg = near_height(int'(cfg_min), 2);
    endcase
    s.support       = H_W'(sup);
    s.support_valid = ($urandom_range(7) != 0);
    s.map_h         = H_W'(zm);
    s.body_h        = H_W'(zb);
    s.grav_h        = H_W'(zg);
    return s;
  endfunction

  task automatic send_item(input kind_t k, input item_t it, input logic typed,
                           input result_t want);
    int      gap;
    result_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_item(it);
    s_axis_tuser  <= k;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (gate_cell_item(k, it, res)) expected_decisions.push_back(typed ? want : res);
  endtask

  task automatic send_cell(input int n_samples);
    item_t it;
    for (int i = 0; i < n_samples; i++) send_item(KIND_SAMPLE, random_sample(), 1'b0, '0);
    // heights of a finish transfer are don't-care, keep them random
    it = random_sample();
    it.status = status_t'($urandom_range(7));
    send_item(KIND_FINISH, it, 1'b0, '0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [H_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIN_HEIGHT: cfg_min  = value[MIN_W-1:0];
      REG_STEP_UP:    cfg_step = value[MIN_W-1:0];
      REG_BODY_CEIL:  cfg_ceil = value;
      default: ;
    endcase
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int    n, sent, mode, minv, stepv, ceilv;
    item_t it;
    clear_cell();

    // decisions on empty cells and with out-of-range finish heights are fixed
    add_row(KIND_FINISH, ST_PROTRUSION, 0, 0, 0, 0, 0, 1, empty_decision(ST_NOSAMPLES, 1));
    add_row(KIND_FINISH, ST_NONE, 0, 0, 0, 0, 0, 1, empty_decision(ST_NONE, 0));
    add_row(KIND_FINISH, ST_EVIDENCE, 0, 0, 0, 0, 0, 1, empty_decision(ST_EVIDENCE, 0));
    add_row(KIND_FINISH, ST_HEIGHT, 0, 0, 0, 0, 0, 1, empty_decision(ST_HEIGHT, 1));
    add_row(KIND_FINISH, ST_NOSAMPLES, 0, 0, 0, 0, 0, 1, empty_decision(ST_NOSAMPLES, 1));
    add_row(KIND_FINISH, ST_DENSE, 0, 0, 0, 0, 0, 1, empty_decision(ST_NOSAMPLES, 1));
    add_row(KIND_FINISH, ST_GEOMFAIL, 0, 0, 0, 0, 0, 1, empty_decision(ST_NOSAMPLES, 1));
    add_row(KIND_FINISH, ST_OVERHEAD, 32767, 1, 32767, -32768, 32767, 1,
            empty_decision(ST_NOSAMPLES, 1));
    add_row(KIND_SAMPLE, ST_NONE, 0, 1, 100, 2000, 0, 0, '0);
    add_row(KIND_FINISH, ST_DENSE, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_SAMPLE, ST_GEOMFAIL, 32767, 1, 32767, -32768, -32768, 0, '0);
    add_row(KIND_SAMPLE, ST_GEOMFAIL, -32768, 1, -32668, 2001, 100, 0, '0);
    add_row(KIND_SAMPLE, ST_OVERHEAD, 0, 0, 32767, 32767, 32767, 0, '0);
    add_row(KIND_FINISH, ST_GEOMFAIL, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_SAMPLE, ST_GEOMFAIL, 0, 1, 151, -1, 99, 0, '0);
    add_row(KIND_SAMPLE, ST_NONE, 0, 1, 150, 0, -5, 0, '0);
    add_row(KIND_FINISH, ST_OVERHEAD, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_SAMPLE, ST_NOSAMPLES, -100, 1, 0, 1999, 0, 0, '0);
    add_row(KIND_FINISH, ST_NONE, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_SAMPLE, ST_EVIDENCE, 100, 1, 199, 2000, 5, 0, '0);
    add_row(KIND_FINISH, ST_PROTRUSION, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_SAMPLE, ST_HEIGHT, 0, 1, -32768, 32767, -32768, 0, '0);
    add_row(KIND_SAMPLE, ST_DENSE, 0, 1, 32767, -32768, 32767, 0, '0);
    add_row(KIND_FINISH, ST_HEIGHT, 0, 0, 0, 0, 0, 0, '0);
    add_row(KIND_FINISH, ST_NONE, 0, 0, 0, 0, 0, 1, empty_decision(ST_NONE, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].it, directed_rows[i].typed,
                directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      mode = p % 4;
      settle();
      send_idle_pct  = (mode == 1) ? 56 : (mode == 3) ? 29 : 0;
      recv_stall_pct = (mode == 2) ? 56 : (mode == 3) ? 29 : 0;
      case (p)
        0: begin
          minv = 0; stepv = 0; ceilv = -32768;
        end
        2: begin
          minv = 32767; stepv = 32767; ceilv = 32767;
        end
        6: begin
          minv = $urandom_range(32767); stepv = $urandom_range(32767);
          ceilv = any_height();
        end
        default: begin
          minv = $urandom_range(400); stepv = $urandom_range(600);
          ceilv = $urandom_range(3000);
          ceilv = ceilv - 500;
        end
      endcase
      // the top bit of a 15-bit register write is don't-care
      write_reg(REG_MIN_HEIGHT, {1'($urandom_range(1)), MIN_W'(minv)});
      write_reg(REG_STEP_UP, {1'($urandom_range(1)), MIN_W'(stepv)});
      write_reg(REG_BODY_CEIL, H_W'(ceilv));
      if (p == 4) write_reg(REG_UNUSED, 16'($urandom));
      cfg_valid <= 1'b0;

      // one long cell of passing samples drives both counts into saturation
      if (p == 1) begin
        for (int i = 0; i < SAT_SAMPLES; i++) begin
          it.status        = ST_NONE;
          it.support       = 16'h8000;
          it.support_valid = 1'b1;
          it.map_h         = H_W'($urandom_range(32767));
          it.body_h        = 16'h8000;
          it.grav_h        = 16'($urandom);
          send_item(KIND_SAMPLE, it, 1'b0, '0);
        end
        it.status = ST_PROTRUSION;
        send_item(KIND_FINISH, it, 1'b0, '0);
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        n = $urandom_range(99);
        if (n < 10) n = 0;
        else if (n < 75) n = $urandom_range(6, 1);
        else if (n < 95) n = $urandom_range(20, 7);
        else n = $urandom_range(60, 21);
        send_cell(n);
        sent += n + 1;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && expected_decisions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
